/* sv/ple_pkg.sv */
// Package for the positional list engine: operation codes, controller states
// and the beat formats of the command and result channels. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_GET    = 3'd2,
        OP_LOCATE = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_VAL,
        S_DEL_FIRST,
        S_DEL_SHIFT,
        S_GET,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]         op;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic               status;
        logic signed [31:0] element;
        logic [6:0]         found_position;
        logic [6:0]         count;
    } t_res;

endpackage

`default_nettype wire

/* sv/ple_stream_if.sv */
// Valid/ready stream interface used by the command and result channels.
// The payload type is a parameter; the beat formats come from ple_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ple_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/positional_list_engine.sv */
// Positional list engine: an ordered list of 32-bit words kept in one
// synchronous memory, with a sequencer for insert, delete, get, locate, clear.
// Depends on ple_pkg and ple_stream_if.
`timescale 1ns / 1ps
`default_nettype none

//  Channel  Dir  Beat     Fields
//  i_cmd    in   t_cmd    op, position, value
//  o_res    out  t_res    status, element, found_position, count
//
// One command is taken at a time; i_cmd.ready is high while the sequencer is
// idle. With p the position, an insert shifts entries p and above up by
// one and a delete shifts the entries above p down by one; a locate reads
// entries in order until the value is found or the list ends. The single
// read port and single write port of the list memory set the pace:
// every entry that moves costs one read and one write, overlapped.
// Reset clears the length and the control state; the memory itself is not
// cleared, and only entries below the length are ever read back.
// A finished result sits in an output register until taken, so the next
// command can be accepted while the result beat is still stalled.

module positional_list_engine #(
    parameter int CAPACITY = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    ple_stream_if.sink         i_cmd,
    ple_stream_if.source       o_res
);
    import ple_pkg::*;

    // Address width, length width, and a compare width that also holds a
    // 7-bit position.
    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = ((FW > 7) ? FW : 7) + 1;

    // List memory.
    logic [31:0] mem_store [CAPACITY];
    logic [31:0] r_rdata;
    logic        mem_we;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] mem_ra;
    logic [31:0] mem_wd;

    t_state r_state, n_state;
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_idx, n_idx;
    logic [6:0]    r_pos, n_pos;
    logic [31:0]   r_val, n_val;
    logic          r_wr_pend, n_wr_pend;
    logic [AW-1:0] r_wr_addr, n_wr_addr;
    t_res          r_res, n_res;
    logic          r_out_valid;
    t_res          r_out;
    logic          load_out;

    logic          in_acc;
    logic          out_free;
    t_op           cmd_op;
    logic [CW-1:0] pos_ext, rpos_ext, fill_ext, idx_ext;
    logic [CW-1:0] cnt_inc, cnt_dec;
    logic          ins_ok, rd_ok;
    logic          more_up, more_down, scan_live, scan_hit;

    assign in_acc   = i_cmd.valid && i_cmd.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign cmd_op   = t_op'(i_cmd.data.op);

    assign pos_ext  = CW'(i_cmd.data.position);
    assign rpos_ext = CW'(r_pos);
    assign fill_ext = CW'(r_fill);
    assign idx_ext  = CW'(r_idx);
    assign cnt_inc  = fill_ext + CW'(1);
    assign cnt_dec  = fill_ext - CW'(1);

    // Range checks on the incoming command against the current length.
    assign ins_ok = (fill_ext < CW'(CAPACITY)) && (pos_ext >= CW'(1))
                 && (pos_ext <= cnt_inc);
    assign rd_ok  = (pos_ext >= CW'(1)) && (pos_ext <= fill_ext);

    // Insert walks down from the top entry; delete and locate walk up.
    assign more_up   = (idx_ext >= rpos_ext);
    assign more_down = (idx_ext < fill_ext);
    assign scan_live = (idx_ext < fill_ext);
    assign scan_hit  = scan_live && (r_rdata == r_val);

    // Memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_store[mem_wa] <= mem_wd;
        end
        r_rdata <= mem_store[mem_ra];
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (cmd_op)
                        OP_INSERT: n_state = ins_ok ? S_INS : S_DONE;
                        OP_DELETE: n_state = rd_ok ? S_DEL_FIRST : S_DONE;
                        OP_GET:    n_state = rd_ok ? S_GET : S_DONE;
                        OP_LOCATE: n_state = S_SCAN;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_INS:       n_state = more_up ? S_INS : S_INS_VAL;
            S_INS_VAL:   n_state = S_DONE;
            S_DEL_FIRST: n_state = more_down ? S_DEL_SHIFT : S_DONE;
            S_DEL_SHIFT: n_state = more_down ? S_DEL_SHIFT : S_DONE;
            S_GET:       n_state = S_DONE;
            S_SCAN:      n_state = (scan_live && !scan_hit) ? S_SCAN : S_DONE;
            S_DONE:      n_state = out_free ? S_IDLE : S_DONE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        mem_we    = 1'b0;
        mem_wa    = r_wr_addr;
        mem_wd    = r_rdata;
        mem_ra    = '0;
        n_idx     = r_idx;
        n_fill    = r_fill;
        n_pos     = r_pos;
        n_val     = r_val;
        n_wr_pend = 1'b0;
        n_wr_addr = r_wr_addr;
        n_res     = r_res;
        load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_pos = i_cmd.data.position;
                    n_val = i_cmd.data.value;
                    mem_ra = AW'(pos_ext - CW'(1));
                    n_res.status         = STATUS_ERR;
                    n_res.element        = '0;
                    n_res.found_position = '0;
                    n_res.count          = fill_ext[6:0];
                    case (cmd_op)
                        OP_INSERT: n_idx = r_fill;
                        OP_DELETE: n_idx = FW'(pos_ext);
                        OP_GET:    n_idx = r_idx;
                        OP_LOCATE: begin
                            mem_ra = '0;
                            n_idx  = '0;
                            n_res.status = STATUS_OK;
                        end
                        OP_CLEAR: begin
                            n_fill       = '0;
                            n_res.status = STATUS_OK;
                            n_res.count  = '0;
                        end
                        default: n_idx = r_idx;
                    endcase
                end
            end
            S_INS: begin
                // Entry idx-1 is read while the previously read entry, idx, is written at idx+1.
                mem_we = r_wr_pend;
                if (more_up) begin
                    mem_ra    = AW'(idx_ext - CW'(1));
                    n_wr_pend = 1'b1;
                    n_wr_addr = AW'(idx_ext);
                    n_idx     = r_idx - FW'(1);
                end
            end
            S_INS_VAL: begin
                mem_we       = 1'b1;
                mem_wa       = AW'(rpos_ext - CW'(1));
                mem_wd       = r_val;
                n_fill       = r_fill + FW'(1);
                n_res.status = STATUS_OK;
                n_res.count  = cnt_inc[6:0];
            end
            S_DEL_FIRST, S_DEL_SHIFT: begin
                if (r_state == S_DEL_FIRST) begin
                    n_res.element = r_rdata;
                end
                mem_we = r_wr_pend;
                if (more_down) begin
                    mem_ra    = AW'(idx_ext);
                    n_wr_pend = 1'b1;
                    n_wr_addr = AW'(idx_ext - CW'(1));
                    n_idx     = r_idx + FW'(1);
                end else begin
                    n_fill       = r_fill - FW'(1);
                    n_res.status = STATUS_OK;
                    n_res.count  = cnt_dec[6:0];
                end
            end
            S_GET: begin
                n_res.element = r_rdata;
                n_res.status  = STATUS_OK;
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_res.found_position = 7'(idx_ext + CW'(1));
                end else if (scan_live) begin
                    if ((idx_ext + CW'(1)) < fill_ext) begin
                        mem_ra = AW'(idx_ext + CW'(1));
                    end
                    n_idx = r_idx + FW'(1);
                end
            end
            S_DONE: load_out = out_free;
            default: load_out = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_wr_pend <= n_wr_pend;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_wr_addr <= n_wr_addr;
        r_res     <= n_res;
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_ext <= CW'(CAPACITY))
        else $error("list length exceeds capacity");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state != S_IDLE) && (r_state != S_DONE))
        else $error("memory written outside an operation");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("accepted command left the sequencer idle");

    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (fill_ext < CW'(CAPACITY)))
        else $error("insert running on a full list");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_free)
        else $error("result loaded over a waiting beat");
`endif

endmodule

`default_nettype wire
